### rtl/mlln_pkg.sv
// ----------------------------------------------------------------------------
// mlln_pkg
// Types and constants shared by the linked node manager and its checker.
// ----------------------------------------------------------------------------
package mlln_pkg;

  localparam int unsigned NumLists  = 4;
  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned ListW     = $clog2(NumLists);
  localparam int unsigned NodeW     = $clog2(PoolNodes);
  localparam int unsigned LinkW     = NodeW + 1;

  localparam logic [LinkW-1:0] NilLink = LinkW'(PoolNodes);

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_INS_BEFORE = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_GET_HEAD   = 3'd4,
    OP_GET_NEXT   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR1,
    ST_WR2
  } state_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [ListW-1:0] list_id;
    logic [NodeW-1:0] anchor_node;
    logic [NodeW-1:0] node;
  } in_t;

  typedef struct packed {
    logic             status;
    logic [LinkW-1:0] result_node;
    logic [LinkW-1:0] free_nodes;
  } out_t;

  typedef struct packed {
    logic             en;
    logic [LinkW-1:0] addr;
    logic [LinkW-1:0] data;
  } link_wr_t;

endpackage

### rtl/multi_list_linked_node_manager.sv
// ----------------------------------------------------------------------------
// multi_list_linked_node_manager
// Doubly linked lists over a shared node pool, links kept in two RAMs.
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 entries of the link RAMs and takes
// no item meanwhile (configuration writes are taken). Each item then goes
// through accept with link RAM read, decide and update head/tail/count, and
// the link write steps WR1 and WR2, since an operation writes up to two
// entries of the same link RAM through its single write port. The result
// sits in an output register while the next item is accepted.
module multi_list_linked_node_manager (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mlln_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mlln_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [mlln_pkg::LinkW-1:0] cfg_data_i
);
  import mlln_pkg::*;

  state_e state_q, state_d;

  logic [LinkW-1:0] prev_mem [PoolNodes];
  logic [LinkW-1:0] next_mem [PoolNodes];
  logic [LinkW-1:0] prev_rd_q, next_rd_q;

  logic [LinkW-1:0] head_q [NumLists];
  logic [LinkW-1:0] tail_q [NumLists];
  logic [LinkW-1:0] head_d, tail_d;
  logic [LinkW-1:0] free_q, free_d, niu_q, limit;

  logic [NodeW-1:0] clr_q;
  in_t              in_q;
  out_t             res_q, res_d, out_q;
  logic             out_valid_q;
  link_wr_t         p1_q, n1_q, p2_q, n2_q, p1_d, n1_d, p2_d, n2_d;
  link_wr_t         pw, nw;

  logic             in_fire, out_free;
  logic [NodeW-1:0] rd_addr;
  logic [LinkW-1:0] h, t, anc, nd;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign limit    = (niu_q > NilLink) ? NilLink : niu_q;
  assign rd_addr  = (in_data_i.operation == OP_INS_AFTER ||
                     in_data_i.operation == OP_INS_BEFORE) ?
                    in_data_i.anchor_node : in_data_i.node;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == NodeW'(PoolNodes - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_fire) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_WR1;
      ST_WR1:   state_d = ST_WR2;
      ST_WR2:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
    pw = '0;
    nw = '0;
    case (state_q)
      ST_CLEAR: begin
        pw = '{en: 1'b1, addr: {1'b0, clr_q}, data: NilLink};
        nw = '{en: 1'b1, addr: {1'b0, clr_q}, data: NilLink};
      end
      ST_WR1: begin
        pw = p1_q;
        nw = n1_q;
      end
      ST_WR2: begin
        if (out_free) begin
          pw = p2_q;
          nw = n2_q;
        end
      end
      default: ;
    endcase
  end

  // decide the operation
  assign h   = head_q[in_q.list_id];
  assign t   = tail_q[in_q.list_id];
  assign anc = {1'b0, in_q.anchor_node};
  assign nd  = {1'b0, in_q.node};

  always_comb begin
    head_d = h;
    tail_d = t;
    free_d = free_q;
    res_d  = '{status: 1'b0, result_node: NilLink, free_nodes: free_q};
    p1_d = '0; n1_d = '0; p2_d = '0; n2_d = '0;
    case (in_q.operation)
      OP_APPEND, OP_INS_AFTER, OP_INS_BEFORE: begin
        if (free_q == '0) begin
          res_d.status = 1'b1;
        end else begin
          free_d = free_q - LinkW'(1);
          if (in_q.operation == OP_APPEND) begin
            n1_d = '{1'b1, nd, NilLink};
            if (h == NilLink) begin
              head_d = nd;
              p1_d   = '{1'b1, nd, NilLink};
            end else begin
              p1_d = '{1'b1, nd, t};
              n2_d = '{1'b1, t, nd};
            end
            tail_d = nd;
          end else if (in_q.operation == OP_INS_AFTER) begin
            p1_d = '{1'b1, nd, anc};
            n2_d = '{1'b1, anc, nd};
            if (t == anc) begin
              n1_d   = '{1'b1, nd, NilLink};
              tail_d = nd;
            end else begin
              n1_d = '{1'b1, nd, next_rd_q};
              p2_d = '{1'b1, next_rd_q, nd};
            end
          end else begin
            if (h == anc) begin
              p1_d   = '{1'b1, h, nd};
              n1_d   = '{1'b1, nd, h};
              p2_d   = '{1'b1, nd, NilLink};
              head_d = nd;
            end else begin
              n1_d = '{1'b1, prev_rd_q, nd};
              p1_d = '{1'b1, anc, nd};
              n2_d = '{1'b1, nd, anc};
              p2_d = '{1'b1, nd, prev_rd_q};
            end
          end
        end
      end
      OP_REMOVE: begin
        if (h == nd) begin
          p1_d   = '{1'b1, next_rd_q, prev_rd_q};
          head_d = next_rd_q;
          if (next_rd_q == NilLink) tail_d = NilLink;
        end else if (t == nd) begin
          n1_d   = '{1'b1, prev_rd_q, next_rd_q};
          tail_d = prev_rd_q;
        end else begin
          n1_d = '{1'b1, prev_rd_q, next_rd_q};
          p1_d = '{1'b1, next_rd_q, prev_rd_q};
        end
        p2_d = '{1'b1, nd, NilLink};
        n2_d = '{1'b1, nd, NilLink};
        if (free_q < limit) free_d = free_q + LinkW'(1);
      end
      OP_GET_HEAD: res_d.result_node = h;
      OP_GET_NEXT: res_d.result_node = next_rd_q;
      default: ;
    endcase
    res_d.free_nodes = free_d;
    if (p1_d.addr >= NilLink) p1_d.en = 1'b0;
    if (n1_d.addr >= NilLink) n1_d.en = 1'b0;
    if (p2_d.addr >= NilLink) p2_d.en = 1'b0;
    if (n2_d.addr >= NilLink) n2_d.en = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pw.en) prev_mem[pw.addr[NodeW-1:0]] <= pw.data;
    if (nw.en) next_mem[nw.addr[NodeW-1:0]] <= nw.data;
    if (in_fire) begin
      prev_rd_q <= prev_mem[rd_addr];
      next_rd_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
    if (state_q == ST_EXEC) begin
      res_q <= res_d;
      p1_q  <= p1_d;
      n1_q  <= n1_d;
      p2_q  <= p2_d;
      n2_q  <= n2_d;
    end
    if (state_q == ST_WR2 && out_free) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      niu_q       <= NilLink;
      free_q      <= NilLink;
      for (int i = 0; i < NumLists; i++) begin
        head_q[i] <= NilLink;
        tail_q[i] <= NilLink;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + NodeW'(1);
      if (state_q == ST_WR2 && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        niu_q  <= cfg_data_i;
        free_q <= (cfg_data_i > NilLink) ? NilLink : cfg_data_i;
      end else if (state_q == ST_EXEC) begin
        free_q <= free_d;
        head_q[in_q.list_id] <= head_d;
        tail_q[in_q.list_id] <= tail_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/mlln_checker.sv
// ----------------------------------------------------------------------------
// mlln_checker
// Port level checks for the linked node manager, bound to the top level.
// ----------------------------------------------------------------------------
module mlln_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mlln_pkg::out_t out_data_o
);
  import mlln_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.free_nodes <= NilLink)
    else $error("free count above pool size");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.result_node <= NilLink)
    else $error("result node out of range");

  a_refuse_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.free_nodes == '0)
    else $error("refusal with free nodes left");

endmodule

bind multi_list_linked_node_manager mlln_checker u_mlln_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
